/* rtl/core/cop_pkg.sv */
// ----------------------------------------------------------------------------
// cop_pkg: shared constants and the pole table for the cascaded one-pole core
// Pole table, fixed widths of the fields, and the configuration register indexes.
// ----------------------------------------------------------------------------
package cop_pkg;

    localparam int MaxSections = 4;
    localparam int Channels    = 2;
    localparam int SampleBits  = 24;
    localparam int SecIdxBits  = 2;
    localparam int ChBits      = 1;
    localparam int CoefBits    = 18;
    localparam int RateBits    = 18;
    localparam int CutoffBits  = 17;

    localparam logic [0:0] RegFilterMode = 1'b0;
    localparam logic [0:0] RegSampleRate = 1'b1;

    function automatic logic [18:0] pole_entry(input logic [5:0] idx);
        logic [18:0] v;
        begin
            case (idx)
                6'd0:  v = 19'd262144; 6'd1:  v = 19'd237631; 6'd2:  v = 19'd215404;
                6'd3:  v = 19'd195262; 6'd4:  v = 19'd177008; 6'd5:  v = 19'd160456;
                6'd6:  v = 19'd145448; 6'd7:  v = 19'd131847; 6'd8:  v = 19'd119521;
                6'd9:  v = 19'd108345; 6'd10: v = 19'd98211;  6'd11: v = 19'd89027;
                6'd12: v = 19'd80705;  6'd13: v = 19'd73158;  6'd14: v = 19'd66315;
                6'd15: v = 19'd60114;  6'd16: v = 19'd54494;  6'd17: v = 19'd49399;
                6'd18: v = 19'd44778;  6'd19: v = 19'd40591;  6'd20: v = 19'd36796;
                6'd21: v = 19'd33356;  6'd22: v = 19'd30236;  6'd23: v = 19'd27408;
                6'd24: v = 19'd24846;  6'd25: v = 19'd22523;  6'd26: v = 19'd20416;
                6'd27: v = 19'd18507;  6'd28: v = 19'd16777;  6'd29: v = 19'd15208;
                6'd30: v = 19'd13786;  6'd31: v = 19'd12497;
                default: v = 19'd11328;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/core/cascaded_one_pole_filter_core.sv */
// ----------------------------------------------------------------------------
// cascaded_one_pole_filter_core: stereo cascade of one-pole sections
// Restoring divider for the pole ratio, table interpolation, then one shared
// multiply-accumulate unit walks the active sections of the selected channel.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 word
//  s_axis    in   s_axis_tvalid/tready      channel, sample_in, cutoff_hz, stages
//  m_axis    out  m_axis_tvalid/tready      sample_out
//  cfg       in   cfg_we (no wait)          filter_mode / rate in Hz
//
//  Steps per word: 1 accept + 33 divider steps + 1 pole step + 3 per active
//  section (read, multiply, accumulate/store) + 1 output load.
//  The serial divider and the shared multiply-accumulate unit let the
//  core work on one word at a time.
//  Reset clears the section state (flip-flops), selects lowpass, rate 48000.
//  Input is ready only in idle; a finished word waits in the output load
//  state while the output register still holds a word not yet taken.
// ----------------------------------------------------------------------------
module cascaded_one_pole_filter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] channel, [24:1] sample_in, [41:25] cutoff_hz, [45:42] stages_requested
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] sample_out
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [cop_pkg::RateBits-1:0] cfg_wdata
);
    import cop_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_POLE = 7'b0000100,
        S_RD   = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                      mode_reg;
    logic [RateBits-1:0]       rate_reg;
    logic signed [SampleBits-1:0] yst_reg [Channels][MaxSections];
    logic signed [SampleBits-1:0] xst_reg [Channels][MaxSections];

    logic [ChBits-1:0]         ch_reg;
    logic [SecIdxBits-1:0]     last_reg;
    logic [SecIdxBits-1:0]     sec_reg;
    logic [5:0]                step_reg;
    logic [32:0]               quo_reg;   // dividend shifts out, quotient shifts in
    logic [RateBits:0]         rem_reg;
    logic [CoefBits-1:0]       coef_reg;
    logic signed [SampleBits-1:0] stin_reg;
    logic signed [SampleBits-1:0] yold_reg, xold_reg;
    logic signed [44:0]        p1_reg, p2_reg;
    logic signed [SampleBits-1:0] out_reg;
    logic                      ovalid_reg;
    logic                      out_load;

    // divider step
    logic [RateBits:0] rem_sh;
    logic              ge;
    assign rem_sh = {rem_reg[RateBits-1:0], quo_reg[32]};
    assign ge     = rem_sh >= {1'b0, rate_reg};

    // pole interpolation
    logic [15:0] ratio;
    logic [5:0]  pidx;
    logic [9:0]  pfrac;
    logic [18:0] t0, t1, pa;
    logic [28:0] dprod;
    always_comb
    begin
        if (rate_reg == '0 || quo_reg[32:15] != '0) ratio = 16'd32768;
        else ratio = quo_reg[15:0];
        pidx  = ratio[15:10];
        pfrac = ratio[9:0];
        t0    = pole_entry(pidx);
        t1    = pole_entry(pidx + 6'd1);
        dprod = 29'(t0 - t1) * 29'(pfrac);
        pa    = (pidx >= 6'd32) ? t0 : t0 - 19'(dprod >> 10);
    end

    // shared multiply-accumulate with rounding and saturation
    logic signed [45:0] acc, sacc;
    logic signed [27:0] rnd;
    logic signed [SampleBits-1:0] ysat;
    logic signed [SampleBits:0]   xdiff;
    assign xdiff = {stin_reg[SampleBits-1], stin_reg} - {xold_reg[SampleBits-1], xold_reg};
    always_comb
    begin
        acc  = 46'(p1_reg) + 46'(p2_reg);
        sacc = acc + 46'sd131072;
        rnd  = 28'(sacc >>> 18);
        if (rnd > 28'sd8388607) ysat = 24'sh7FFFFF;
        else if (rnd < -28'sd8388608) ysat = 24'sh800000;
        else ysat = rnd[SampleBits-1:0];
    end

    logic [3:0] req;
    assign req = s_axis_tdata[45:42];

    // finished word moves to the output register once that register is free
    assign out_load      = (state_reg == S_OUT) && (!ovalid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_DIV;
            S_DIV:  if (step_reg == 6'd0) state_next = S_POLE;
            S_POLE: state_next = S_RD;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (sec_reg == last_reg) ? S_OUT : S_RD;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b0;
            rate_reg   <= 18'd48000;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < Channels; c++)
                for (int k = 0; k < MaxSections; k++)
                begin
                    yst_reg[c][k] <= '0;
                    xst_reg[c][k] <= '0;
                end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    RegFilterMode: mode_reg <= cfg_wdata[0];
                    RegSampleRate: rate_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
            if (state_reg == S_ACC)
            begin
                yst_reg[ch_reg][sec_reg] <= ysat;
                if (mode_reg) xst_reg[ch_reg][sec_reg] <= stin_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ch_reg   <= s_axis_tdata[0];
                stin_reg <= s_axis_tdata[24:1];
                quo_reg  <= {s_axis_tdata[41:25], 16'd0};
                rem_reg  <= '0;
                step_reg <= 6'd32;
                sec_reg  <= '0;
                if (req == 4'd0) last_reg <= '0;
                else if (req > 4'(MaxSections)) last_reg <= SecIdxBits'(MaxSections - 1);
                else last_reg <= SecIdxBits'(req - 4'd1);
            end
            S_DIV:
            begin
                // 33 quotient bits; the clamp test looks at the upper 18 bits [32:15]
                rem_reg  <= ge ? rem_sh - {1'b0, rate_reg} : rem_sh;
                quo_reg  <= {quo_reg[31:0], ge};
                step_reg <= step_reg - 6'd1;
            end
            S_POLE: coef_reg <= (pa > 19'd262143) ? 18'd262143 : pa[CoefBits-1:0];
            S_RD:
            begin
                yold_reg <= yst_reg[ch_reg][sec_reg];
                xold_reg <= xst_reg[ch_reg][sec_reg];
            end
            S_MUL:
            begin
                p1_reg <= 45'($signed({1'b0, coef_reg}) * yold_reg);
                if (mode_reg) p2_reg <= 45'(xdiff) <<< 18;
                else p2_reg <= 45'($signed({1'b0, 19'd262144 - {1'b0, coef_reg}}) * stin_reg);
            end
            S_ACC:
            begin
                stin_reg <= ysat;
                sec_reg  <= sec_reg + 1'b1;
            end
            S_OUT: if (out_load) out_reg <= stin_reg;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_axis_tready)
        else $error("accept while busy");
    a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> sec_reg <= last_reg)
        else $error("section index past last");
`endif

endmodule
